@@ design/ecs_pkg.sv @@
// Shared types and constants of the elevator call scheduler.
// Used by every module of the block; it depends on nothing else.
package ecs_pkg;

   localparam int MAX_FLOORS = 32;
   localparam int COUNT_BITS = 4;
   localparam int IDX_W      = $clog2(MAX_FLOORS);
   localparam int FLOOR_W    = 6;
   localparam int CSR_DATA_W = 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [FLOOR_W-1:0] FLOOR_ONE   = FLOOR_W'(1);
   localparam logic [FLOOR_W-1:0] FLOOR_MIN_TOP = FLOOR_W'(2);
   localparam logic [FLOOR_W-1:0] FLOOR_MAX_TOP = FLOOR_W'(MAX_FLOORS);
   localparam logic [FLOOR_W-1:0] FLOOR_COUNT_RESET = FLOOR_W'(32);

   // Operation codes of an input beat.
   localparam logic [1:0] OP_UP_CALL   = 2'd0;
   localparam logic [1:0] OP_DOWN_CALL = 2'd1;
   localparam logic [1:0] OP_STEP      = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_FLOOR_COUNT = 1'b0;
   localparam logic CSR_CAR_ID      = 1'b1;

   typedef struct packed {
      logic [1:0]         op;
      logic [FLOOR_W-1:0] call_floor;
   } req_type;

   typedef struct packed {
      logic [7:0]            car;
      logic [FLOOR_W-1:0]    floor_now;
      logic                  heading_up;
      logic [COUNT_BITS-1:0] arrivals;
      logic [FLOOR_W-1:0]    served_floor;
      logic                  served_up;
      logic                  busy_res;
   } rsp_type;

   // Lowest and highest occupied floor (1-based) of one call store.
   typedef struct packed {
      logic               any;
      logic [FLOOR_W-1:0] lo;
      logic [FLOOR_W-1:0] hi;
   } span_type;

endpackage

@@ design/ecs_span.sv @@
// Priority encoders giving the lowest and highest pending floor of a store.
// Depends on ecs_pkg.
module ecs_span (
   input  logic [ecs_pkg::MAX_FLOORS-1:0] occ,
   output ecs_pkg::span_type              span
);

   logic [ecs_pkg::FLOOR_W-1:0] lo;
   logic [ecs_pkg::FLOOR_W-1:0] hi;

   always_comb begin
      lo = '0;
      hi = '0;
      for (int i = 0; i < ecs_pkg::MAX_FLOORS; i++) begin
         if (occ[i]) begin
            hi = ecs_pkg::FLOOR_W'(i + 1);
         end
      end
      for (int i = ecs_pkg::MAX_FLOORS - 1; i >= 0; i--) begin
         if (occ[i]) begin
            lo = ecs_pkg::FLOOR_W'(i + 1);
         end
      end
   end

   assign span.any = |occ;
   assign span.lo  = lo;
   assign span.hi  = hi;

endmodule

@@ design/ecs_count_store.sv @@
// Per-floor saturating call counters of one direction, with occupancy bits.
// Depends on ecs_pkg.
module ecs_count_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ecs_pkg::IDX_W-1:0]       addr,
   input  logic                            inc,
   input  logic                            clr,
   output logic [ecs_pkg::COUNT_BITS-1:0]  rd_count,
   output logic [ecs_pkg::MAX_FLOORS-1:0]  occ
);

   logic [ecs_pkg::COUNT_BITS-1:0] cnt_ff [ecs_pkg::MAX_FLOORS];
   logic [ecs_pkg::COUNT_BITS-1:0] cnt_in;

   assign rd_count = cnt_ff[addr];

   always_comb begin
      cnt_in = rd_count;
      if (clr) begin
         cnt_in = '0;
      end else if (inc && (rd_count != ecs_pkg::COUNT_MAX)) begin
         cnt_in = rd_count + ecs_pkg::COUNT_BITS'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < ecs_pkg::MAX_FLOORS; i++) begin
         occ[i] = (cnt_ff[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ecs_pkg::MAX_FLOORS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (inc || clr) begin
         cnt_ff[addr] <= cnt_in;
      end
   end

endmodule

@@ design/elevator_call_scheduler_core.sv @@
// Top level of the single-car SCAN call scheduler: handshake registers,
// car position and direction, and the move decision. Depends on ecs_pkg,
// ecs_count_store and ecs_span.
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+----------
//   request  | req_valid, req_stall, req_data         | in
//   response | rsp_valid, rsp_stall, rsp_data         | out
//   csr      | csr_we, csr_index, csr_wdata           | in
//
// Each beat is registered at the input, processed combinationally (the priority
// encoders over the occupancy bits lie on that path) and its status lands in the
// output register; one beat per cycle is sustained while rsp_stall is low.
// Reset clears both call stores, puts the car at floor 1 heading up and sets
// floor_count to 32 and car_id to 0. A stalled response holds the output
// register and, once the input register is also full, stalls the request side.
module elevator_call_scheduler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ecs_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ecs_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [ecs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                        req_valid_ff;
   ecs_pkg::req_type            req_ff;
   logic                        rsp_valid_ff;
   ecs_pkg::rsp_type            rsp_ff;
   ecs_pkg::rsp_type            rsp_in;
   logic [ecs_pkg::FLOOR_W-1:0] position_ff;
   logic [ecs_pkg::FLOOR_W-1:0] position_in;
   logic                        going_up_ff;
   logic                        going_up_in;
   logic [ecs_pkg::FLOOR_W-1:0] floor_count_ff;
   logic [7:0]                  car_id_ff;

   logic                            advance;
   logic                            accept;
   logic                            is_up;
   logic                            is_down;
   logic                            is_step;
   logic                            floor_ok;
   logic                            step_go;
   logic [ecs_pkg::FLOOR_W-1:0]     addr_full;
   logic [ecs_pkg::IDX_W-1:0]       addr;
   logic [ecs_pkg::MAX_FLOORS-1:0]  addr_bit;
   logic                            up_inc;
   logic                            up_clr;
   logic                            dn_inc;
   logic                            dn_clr;
   logic [ecs_pkg::COUNT_BITS-1:0]  up_count;
   logic [ecs_pkg::COUNT_BITS-1:0]  dn_count;
   logic [ecs_pkg::MAX_FLOORS-1:0]  up_occ;
   logic [ecs_pkg::MAX_FLOORS-1:0]  dn_occ;
   logic [ecs_pkg::MAX_FLOORS-1:0]  up_occ_after;
   logic [ecs_pkg::MAX_FLOORS-1:0]  dn_occ_after;
   ecs_pkg::span_type               up_span;
   ecs_pkg::span_type               dn_span;
   logic [ecs_pkg::FLOOR_W-1:0]     top_floor;
   logic                            reverse;
   logic [ecs_pkg::COUNT_BITS-1:0]  arrivals;

   // The input register advances when the output register is free or drains.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign is_up    = (req_ff.op == ecs_pkg::OP_UP_CALL);
   assign is_down  = (req_ff.op == ecs_pkg::OP_DOWN_CALL);
   assign is_step  = (req_ff.op == ecs_pkg::OP_STEP);
   assign floor_ok = (req_ff.call_floor != '0) &&
                     (req_ff.call_floor <= ecs_pkg::FLOOR_MAX_TOP);
   assign step_go  = is_step && ((|up_occ) || (|dn_occ));

   assign addr_full = is_step ? (position_ff - ecs_pkg::FLOOR_ONE)
                              : (req_ff.call_floor - ecs_pkg::FLOOR_ONE);
   assign addr      = addr_full[ecs_pkg::IDX_W-1:0];
   assign addr_bit  = ecs_pkg::MAX_FLOORS'(1) << addr;

   assign up_inc = advance && is_up && floor_ok;
   assign dn_inc = advance && is_down && floor_ok;
   assign up_clr = advance && step_go && going_up_ff;
   assign dn_clr = advance && step_go && !going_up_ff;

   ecs_count_store u_up_store (
      .clock    (clock),
      .reset    (reset),
      .addr     (addr),
      .inc      (up_inc),
      .clr      (up_clr),
      .rd_count (up_count),
      .occ      (up_occ)
   );

   ecs_count_store u_dn_store (
      .clock    (clock),
      .reset    (reset),
      .addr     (addr),
      .inc      (dn_inc),
      .clr      (dn_clr),
      .rd_count (dn_count),
      .occ      (dn_occ)
   );

   // Occupancy as it stands once this beat has been applied.
   always_comb begin
      up_occ_after = up_occ;
      dn_occ_after = dn_occ;
      if (is_up && floor_ok) begin
         up_occ_after = up_occ | addr_bit;
      end
      if (is_down && floor_ok) begin
         dn_occ_after = dn_occ | addr_bit;
      end
      if (step_go && going_up_ff) begin
         up_occ_after = up_occ & ~addr_bit;
      end
      if (step_go && !going_up_ff) begin
         dn_occ_after = dn_occ & ~addr_bit;
      end
   end

   ecs_span u_up_span (.occ(up_occ_after), .span(up_span));
   ecs_span u_dn_span (.occ(dn_occ_after), .span(dn_span));

   always_comb begin
      if (floor_count_ff < ecs_pkg::FLOOR_MIN_TOP) begin
         top_floor = ecs_pkg::FLOOR_MIN_TOP;
      end else if (floor_count_ff > ecs_pkg::FLOOR_MAX_TOP) begin
         top_floor = ecs_pkg::FLOOR_MAX_TOP;
      end else begin
         top_floor = floor_count_ff;
      end
   end

   // SCAN: reverse at travel end or if one store alone has calls, none ahead.
   always_comb begin
      if (going_up_ff) begin
         reverse = (position_ff >= top_floor) ||
                   (!up_span.any && dn_span.any && (dn_span.lo < position_ff) &&
                    (dn_span.hi < position_ff)) ||
                   (up_span.any && (up_span.hi <= position_ff) && !dn_span.any);
      end else begin
         reverse = (position_ff <= ecs_pkg::FLOOR_ONE) ||
                   (dn_span.any && (dn_span.lo >= position_ff) && !up_span.any) ||
                   (!dn_span.any && up_span.any && (up_span.hi >= position_ff) &&
                    (up_span.lo > position_ff));
      end
   end

   always_comb begin
      position_in = position_ff;
      going_up_in = going_up_ff;
      arrivals    = '0;
      if (step_go) begin
         arrivals = going_up_ff ? up_count : dn_count;
         if (reverse) begin
            going_up_in = !going_up_ff;
         end else if (going_up_ff) begin
            position_in = position_ff + ecs_pkg::FLOOR_ONE;
         end else begin
            position_in = position_ff - ecs_pkg::FLOOR_ONE;
         end
      end
   end

   always_comb begin
      rsp_in.car          = car_id_ff;
      rsp_in.floor_now    = position_in;
      rsp_in.heading_up   = going_up_in;
      rsp_in.arrivals     = arrivals;
      rsp_in.served_floor = position_ff;
      rsp_in.served_up    = going_up_ff;
      rsp_in.busy_res     = up_span.any || dn_span.any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         position_ff    <= ecs_pkg::FLOOR_ONE;
         going_up_ff    <= 1'b1;
         floor_count_ff <= ecs_pkg::FLOOR_COUNT_RESET;
         car_id_ff      <= '0;
      end else begin
         if (accept) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            position_ff  <= position_in;
            going_up_ff  <= going_up_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               ecs_pkg::CSR_FLOOR_COUNT: begin
                  floor_count_ff <= csr_wdata[ecs_pkg::FLOOR_W-1:0];
               end
               ecs_pkg::CSR_CAR_ID: begin
                  car_id_ff <= csr_wdata[7:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/ecs_checker.sv @@
// Port-level checks of the elevator call scheduler, bound to its top level.
// Depends on ecs_pkg and elevator_call_scheduler_core.
module ecs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ecs_pkg::rsp_type rsp_data
);

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // With the output register empty the request side never stalls.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output register");

   // A reversal happens in place.
   a_reverse_in_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.heading_up != rsp_data.served_up) |->
      rsp_data.floor_now == rsp_data.served_floor)
      else $error("car moved while reversing");

   // A move is one floor in the direction of travel.
   a_one_floor_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.floor_now != rsp_data.served_floor) |->
      (rsp_data.heading_up &&
       (rsp_data.floor_now == rsp_data.served_floor + ecs_pkg::FLOOR_ONE)) ||
      (!rsp_data.heading_up &&
       (rsp_data.floor_now + ecs_pkg::FLOOR_ONE == rsp_data.served_floor)))
      else $error("car moved by other than one floor");

endmodule

bind elevator_call_scheduler_core ecs_checker u_ecs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
